FILE: rtl/eac_pkg.sv
// Shared types and constants of the encoder angle and speed estimator.
package eac_pkg;

  localparam int CNT_W    = 16;
  localparam int ANGLE_W  = 15;
  localparam int POS_W    = 16;
  localparam int SPEED_W  = 17;
  localparam int PPR_W    = 15;
  localparam int GEAR_W   = 16;
  localparam int MAX_W    = 16;
  localparam int SCALE_W  = 24;
  localparam int TICK_W   = 5;
  localparam int SUM_W    = 9;
  localparam int TOTAL_W  = 17;
  localparam int MAG_W    = 16;
  localparam int SPD_A_W  = 22;
  localparam int SPD_N_W  = SPD_A_W + SCALE_W;
  localparam int SPD_D_W  = PPR_W + TICK_W;
  localparam int POS_N_W  = CNT_W + GEAR_W;
  localparam int HOLD_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic signed [CNT_W-1:0] SMALL_DELTA  = 16'sd10;
  localparam logic [TICK_W-1:0]       WINDOW_LIMIT = 5'd20;
  localparam logic [SPD_A_W-1:0]      SPEED_FACTOR = 22'd100;

  typedef enum logic [2:0] {
    REG_COUNT_DOWN  = 3'd0,
    REG_PULSES      = 3'd1,
    REG_GEAR_NUM    = 3'd2,
    REG_GEAR_DEN    = 3'd3,
    REG_MAX_SPEED   = 3'd4,
    REG_SPEED_SCALE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               count_down;
    logic [PPR_W-1:0]   pulses_per_rev;
    logic [GEAR_W-1:0]  gear_num;
    logic [GEAR_W-1:0]  gear_den;
    logic [MAX_W-1:0]   max_speed;
    logic [SCALE_W-1:0] speed_scale;
  } cfg_t;

  localparam logic [PPR_W-1:0]   PULSES_RESET = 15'd4096;
  localparam logic [GEAR_W-1:0]  GEAR_RESET   = 16'd1;
  localparam logic [MAX_W-1:0]   MAX_RESET    = 16'd6000;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd2000;

endpackage

FILE: rtl/eac_if.sv
// Valid/ready channel interfaces for encoder samples and estimator results.
interface eac_in_if import eac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] counter_value;

  modport source (output valid, output counter_value, input ready);
  modport sink   (input valid, input counter_value, output ready);
endinterface

interface eac_out_if import eac_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ANGLE_W-1:0]        angle;
  logic [POS_W-1:0]          position_ref;
  logic signed [SPEED_W-1:0] speed;

  modport source (output valid, output angle, output position_ref, output speed, input ready);
  modport sink   (input valid, input angle, input position_ref, input speed, output ready);
endinterface

FILE: rtl/eac_cfg.sv
// APB-style configuration register file of the estimator.
module eac_cfg import eac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_COUNT_DOWN:  cfg_nxt.count_down     = pwdata[0];
        REG_PULSES:      cfg_nxt.pulses_per_rev = pwdata[PPR_W-1:0];
        REG_GEAR_NUM:    cfg_nxt.gear_num       = pwdata[GEAR_W-1:0];
        REG_GEAR_DEN:    cfg_nxt.gear_den       = pwdata[GEAR_W-1:0];
        REG_MAX_SPEED:   cfg_nxt.max_speed      = pwdata[MAX_W-1:0];
        REG_SPEED_SCALE: cfg_nxt.speed_scale    = pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COUNT_DOWN:  prdata = DATA_W'(cfg_r.count_down);
      REG_PULSES:      prdata = DATA_W'(cfg_r.pulses_per_rev);
      REG_GEAR_NUM:    prdata = DATA_W'(cfg_r.gear_num);
      REG_GEAR_DEN:    prdata = DATA_W'(cfg_r.gear_den);
      REG_MAX_SPEED:   prdata = DATA_W'(cfg_r.max_speed);
      REG_SPEED_SCALE: prdata = DATA_W'(cfg_r.speed_scale);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_down     <= 1'b0;
      cfg_r.pulses_per_rev <= PULSES_RESET;
      cfg_r.gear_num       <= GEAR_RESET;
      cfg_r.gear_den       <= GEAR_RESET;
      cfg_r.max_speed      <= MAX_RESET;
      cfg_r.speed_scale    <= SCALE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/eac_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module eac_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r, a_nxt;
  logic [AW+BW-1:0] p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [AW:0]      sum;

  // add the multiplicand into the upper half when the low bit is set
  assign sum  = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
  assign done = done_r;
  assign prod = p_r;

  always_comb begin
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      p_nxt    = {{AW{1'b0}}, b};
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[BW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

endmodule

FILE: rtl/eac_div.sv
// Restoring divider, one quotient bit per cycle, most significant first.
module eac_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial    = {rem_r, q_r[NW-1]};
  assign diff     = trial - {1'b0, dv_r};
  assign ge       = trial >= {1'b0, dv_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_nxt   = {q_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

endmodule

FILE: rtl/encoder_angle_and_speed_estimator_top.sv
// Top level of the incremental encoder angle, position and speed estimator.
//
// Usage:
//   in_ch  carries one raw 16-bit encoder counter sample per control tick
//          (valid/ready, accepted when both are high).
//   out_ch returns one item per sample: angle within the revolution,
//          geared position reference and clamped signed speed.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready is an APB-style register
//          port; register i sits at byte address 4*i, pready is tied high.
//          Write registers only while no sample is in flight.
// Processing:
//   The position path runs a bit-serial multiply and then a bit-serial divide;
//   when a speed update is due, the speed path runs its own bit-serial multiply
//   and divide in parallel. One sample is worked on at a time; the next is
//   accepted as soon as the result sits in the output register, even while
//   that result still waits to be taken.
// Reset clears the tracked base count, previous count, speed window and held
// speed, and loads the register defaults. A stalled receiver holds the result;
// a finished next result then waits in the clamp state until the slot frees.
module encoder_angle_and_speed_estimator_top import eac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  eac_in_if.sink            in_ch,
  eac_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_RUN,
    S_FIN,
    S_CLAMP
  } state_t;

  cfg_t cfg;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           base_r, base_nxt;
  logic [CNT_W-1:0]           prev_r, prev_nxt;
  logic [TICK_W-1:0]          ticks_r, ticks_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SPEED_W-1:0]  hold_r, hold_nxt;
  logic [CNT_W-1:0]           theta_r, theta_nxt;
  logic [MAG_W-1:0]           mag_r, mag_nxt;
  logic                       neg_r, neg_nxt;
  logic [TICK_W-1:0]          tick_c_r, tick_c_nxt;
  logic                       do_spd_r, do_spd_nxt;
  logic [SPD_D_W-1:0]         den_r, den_nxt;
  logic                       pos_ok_r, pos_ok_nxt;
  logic                       spd_ok_r, spd_ok_nxt;
  logic signed [HOLD_W-1:0]   v_r, v_nxt;
  logic [POS_W-1:0]           pos_res_r, pos_res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ANGLE_W-1:0]         out_angle_r, out_angle_nxt;
  logic [POS_W-1:0]           out_pos_r, out_pos_nxt;
  logic signed [SPEED_W-1:0]  out_speed_r, out_speed_nxt;

  // angle and window logic
  logic [CNT_W-1:0]           n16;
  logic [CNT_W-1:0]           sw;
  logic [CNT_W-1:0]           neg_sw;
  logic [CNT_W-1:0]           delta;
  logic                       small_delta;
  logic [TICK_W-1:0]          tick_inc;
  logic signed [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]         total_abs;
  logic signed [HOLD_W-1:0]   max_pos;
  logic signed [HOLD_W-1:0]   max_neg;
  logic signed [SPEED_W-1:0]  clamped;
  logic [HOLD_W-1:0]          q_lo;

  // serial arithmetic
  logic                       pos_mul_start, pos_mul_done;
  logic [POS_N_W-1:0]         pos_prod;
  logic                       pos_div_done;
  logic [POS_N_W-1:0]         pos_quo;
  logic                       spd_mul_start, spd_mul_done;
  logic [SPD_A_W-1:0]         spd_a;
  logic [SPD_N_W-1:0]         spd_prod;
  logic                       spd_div_done;
  logic [SPD_N_W-1:0]         spd_quo;

  eac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // geared position: theta * gear_den, then / gear_num
  assign pos_mul_start = (state_r == S_START);

  eac_mul #(.AW(CNT_W), .BW(GEAR_W)) u_pos_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pos_mul_start),
    .a     (theta_r),
    .b     (cfg.gear_den),
    .done  (pos_mul_done),
    .prod  (pos_prod)
  );

  eac_div #(.NW(POS_N_W), .DW(GEAR_W)) u_pos_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pos_mul_done),
    .dividend (pos_prod),
    .divisor  (cfg.gear_num),
    .done     (pos_div_done),
    .quotient (pos_quo)
  );

  // speed: |sum| * 100 * speed_scale, then / (pulses_per_rev * ticks)
  assign spd_mul_start = (state_r == S_START) && do_spd_r;
  assign spd_a         = SPD_A_W'(mag_r) * SPEED_FACTOR;

  eac_mul #(.AW(SPD_A_W), .BW(SCALE_W)) u_spd_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (spd_mul_start),
    .a     (spd_a),
    .b     (cfg.speed_scale),
    .done  (spd_mul_done),
    .prod  (spd_prod)
  );

  eac_div #(.NW(SPD_N_W), .DW(SPD_D_W)) u_spd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (spd_mul_done),
    .dividend (spd_prod),
    .divisor  (den_r),
    .done     (spd_div_done),
    .quotient (spd_quo)
  );

  // channel hookup
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.angle        = out_angle_r;
  assign out_ch.position_ref = out_pos_r;
  assign out_ch.speed        = out_speed_r;

  // angle relative to base, and signed tick-to-tick delta (both mod 2^16)
  assign n16         = {1'b0, cfg.pulses_per_rev};
  assign sw          = cnt_r - base_r;
  assign neg_sw      = CNT_W'(0) - sw;
  assign delta       = cnt_r - prev_r;
  assign small_delta = ($signed(delta) <= SMALL_DELTA) && ($signed(delta) >= -SMALL_DELTA);
  assign tick_inc    = ticks_r + 1'b1;
  assign total       = $signed({delta[CNT_W-1], delta}) + TOTAL_W'(sum_r);
  assign total_abs   = total[TOTAL_W-1] ? (TOTAL_W'(0) - total) : total;

  // clamp the held speed to +-max_speed
  assign max_pos = $signed(HOLD_W'(cfg.max_speed));
  assign max_neg = HOLD_W'(0) - max_pos;
  assign q_lo    = spd_quo[HOLD_W-1:0];

  always_comb begin
    if (v_r >= max_pos) begin
      clamped = $signed({1'b0, cfg.max_speed});
    end else if (v_r <= max_neg) begin
      clamped = max_neg[SPEED_W-1:0];
    end else begin
      clamped = v_r[SPEED_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    prev_nxt      = prev_r;
    ticks_nxt     = ticks_r;
    sum_nxt       = sum_r;
    hold_nxt      = hold_r;
    theta_nxt     = theta_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    tick_c_nxt    = tick_c_r;
    do_spd_nxt    = do_spd_r;
    den_nxt       = den_r;
    pos_ok_nxt    = pos_ok_r || pos_div_done;
    spd_ok_nxt    = spd_ok_r || spd_div_done;
    v_nxt         = v_r;
    pos_res_nxt   = pos_res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_angle_nxt = out_angle_r;
    out_pos_nxt   = out_pos_r;
    out_speed_nxt = out_speed_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          // mirror the count when counting down: 65535 - x is ~x
          cnt_nxt   = cfg.count_down ? ~in_ch.counter_value : in_ch.counter_value;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        // move the base by at most one revolution toward the sample
        if (!sw[CNT_W-1]) begin
          if (sw >= n16) begin
            theta_nxt = sw - n16;
            base_nxt  = base_r + n16;
          end else begin
            theta_nxt = sw;
          end
        end else begin
          if (neg_sw >= n16) begin
            theta_nxt = sw + n16 + n16;
            base_nxt  = base_r - n16;
          end else begin
            theta_nxt = sw + n16;
          end
        end

        // accumulate small deltas; flush on a large one or a full window
        mag_nxt    = total_abs[MAG_W-1:0];
        neg_nxt    = total[TOTAL_W-1];
        tick_c_nxt = tick_inc;
        if (small_delta && (tick_inc <= WINDOW_LIMIT)) begin
          do_spd_nxt = 1'b0;
          ticks_nxt  = tick_inc;
          sum_nxt    = total[SUM_W-1:0];
        end else begin
          do_spd_nxt = 1'b1;
          ticks_nxt  = '0;
          sum_nxt    = '0;
        end
        prev_nxt  = cnt_r;
        state_nxt = S_START;
      end

      S_START: begin
        den_nxt    = SPD_D_W'(cfg.pulses_per_rev) * SPD_D_W'(tick_c_r);
        pos_ok_nxt = 1'b0;
        spd_ok_nxt = !do_spd_r;
        state_nxt  = S_RUN;
      end

      S_RUN: begin
        if (pos_ok_r && spd_ok_r) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        pos_res_nxt = (cfg.gear_num == '0) ? '0 : pos_quo[POS_W-1:0];
        if (!do_spd_r) begin
          v_nxt = HOLD_W'(hold_r);
        end else if (den_r == '0) begin
          v_nxt = '0;
        end else begin
          // quotient keeps its low 32 bits, then takes the sign back
          v_nxt = neg_r ? $signed(HOLD_W'(0) - q_lo) : $signed(q_lo);
        end
        state_nxt = S_CLAMP;
      end

      S_CLAMP: begin
        hold_nxt = clamped;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = theta_r[ANGLE_W-1:0];
          out_pos_nxt   = pos_res_r;
          out_speed_nxt = clamped;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      prev_r      <= '0;
      ticks_r     <= '0;
      sum_r       <= '0;
      hold_r      <= '0;
      pos_ok_r    <= 1'b0;
      spd_ok_r    <= 1'b0;
      do_spd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      prev_r      <= prev_nxt;
      ticks_r     <= ticks_nxt;
      sum_r       <= sum_nxt;
      hold_r      <= hold_nxt;
      pos_ok_r    <= pos_ok_nxt;
      spd_ok_r    <= spd_ok_nxt;
      do_spd_r    <= do_spd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r       <= cnt_nxt;
    theta_r     <= theta_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    tick_c_r    <= tick_c_nxt;
    den_r       <= den_nxt;
    v_r         <= v_nxt;
    pos_res_r   <= pos_res_nxt;
    out_angle_r <= out_angle_nxt;
    out_pos_r   <= out_pos_nxt;
    out_speed_r <= out_speed_nxt;
  end

endmodule
